/* hw/rtl/spmq_pkg.sv */
package spmq_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CTRL,
    ST_RDATA,
    ST_SCAN
  } state_t;

  typedef enum logic [2:0] {
    STS_PUSHED  = 3'd0,
    STS_DROPPED = 3'd1,
    STS_POPPED  = 3'd2,
    STS_EMPTY   = 3'd3,
    STS_SUSPEND = 3'd4,
    STS_STOPPED = 3'd5
  } status_t;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  localparam logic [2:0] CLASS_VERY_LOW = 3'd0;
  localparam logic [2:0] CLASS_LOW      = 3'd1;
  localparam logic [2:0] CLASS_MEDIUM   = 3'd2;
  localparam logic [2:0] CLASS_HIGH     = 3'd3;

  // register select is paddr[2]
  localparam logic REG_SUSPEND = 1'b0;
  localparam logic REG_STOP    = 1'b1;

endpackage

/* hw/rtl/strict_priority_multi_queue_unit.sv */
// Channel   | Signals                                           | Handshake
// ----------+---------------------------------------------------+------------------------------
// request   | kind task_handle level use_class prio_class       | start & !busy
// result    | status out_handle out_level total_count top_valid | done, one cycle, no backpressure
//           | top_level                                         |
// config    | psel penable pwrite paddr pwdata prdata pready    | APB write, pready tied high
//
// Push: control memory read, then write-back; done in the next cycle, where a new request
// is already taken. Rejected pop (stopped, suspended, empty): answered from idle.
// Pop: control read, task memory read, handle capture, plus a one-level-per-cycle downward
// scan of the non-empty flags when a level above level 0 empties.
// Reset is synchronous; queues come up empty at once, no clearing pass.
// The receiver cannot stall: done is a single-cycle strobe.
module strict_priority_multi_queue_unit #(
  parameter int NUM_LEVELS   = 8,
  parameter int QUEUE_DEPTH  = 16,
  parameter int HANDLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    kind,
  input  logic [HANDLE_WIDTH-1:0] task_handle,
  input  logic [9:0]              level,
  input  logic                    use_class,
  input  logic [2:0]              prio_class,
  output logic                    done,
  output logic [2:0]              status,
  output logic [15:0]             out_handle,
  output logic [2:0]              out_level,
  output logic [7:0]              total_count,
  output logic                    top_valid,
  output logic [2:0]              top_level,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int LW = $clog2(NUM_LEVELS);
  localparam int HW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = HW + 1;
  localparam int ENTRIES = NUM_LEVELS * QUEUE_DEPTH;
  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int CTW = HW + FW;

  localparam logic [10:0] LV_LOW  = 11'(NUM_LEVELS / 4);
  localparam logic [10:0] LV_MED  = 11'(NUM_LEVELS / 2);
  localparam logic [10:0] LV_HIGH = 11'((NUM_LEVELS * 3) / 4);
  localparam logic [10:0] LV_TOP  = 11'(NUM_LEVELS);
  localparam logic [10:0] LV_MAX  = 11'(NUM_LEVELS - 1);

  spmq_pkg::state_t  state, state_next;
  spmq_pkg::status_t res_status;

  logic                    suspend_flag, stop_flag;
  logic                    cfg_wr;

  logic                    kind_q;
  logic [HANDLE_WIDTH-1:0] handle_q;
  logic [LW-1:0]           lvl_q;
  logic                    pop_last;
  logic [LW-1:0]           scan_idx;

  logic [HANDLE_WIDTH-1:0] res_handle;
  logic [LW-1:0]           res_level;
  logic                    done_q;

  logic [NUM_LEVELS-1:0]   nonempty;
  logic [CW-1:0]           count;
  logic                    highest_valid;
  logic [LW-1:0]           highest_level;

  logic [10:0]             req_level;
  logic [LW-1:0]           push_level;
  logic [LW-1:0]           lvl_in;
  logic                    accept;
  logic                    reject_pop;

  logic [CTW-1:0]          ctrl_mem [NUM_LEVELS];
  logic [CTW-1:0]          ctrl_rd;
  logic [CTW-1:0]          ctrl_wdata;
  logic                    ctrl_re, ctrl_we;

  logic [HANDLE_WIDTH-1:0] task_mem [ENTRIES];
  logic [HANDLE_WIDTH-1:0] tm_rdata;
  logic [AW-1:0]           tm_addr;
  logic                    tm_we, tm_re;

  logic [HW-1:0]           eff_head;
  logic [FW-1:0]           eff_fill;
  logic [SW-1:0]           tail_sum;
  logic [HW-1:0]           tail_pos;
  logic [HW-1:0]           head_inc;
  logic                    is_full;

  // ---------------- configuration ----------------
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == spmq_pkg::REG_STOP) ? 32'(stop_flag) : 32'(suspend_flag);

  always_ff @(posedge clk) begin
    if (rst) begin
      suspend_flag <= 1'b0;
      stop_flag    <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == spmq_pkg::REG_STOP) begin
        stop_flag <= pwdata[0];
      end else begin
        suspend_flag <= pwdata[0];
      end
    end
  end

  // ---------------- request decode ----------------
  always_comb begin
    if (use_class) begin
      case (prio_class)
        spmq_pkg::CLASS_VERY_LOW: req_level = 11'd0;
        spmq_pkg::CLASS_LOW:      req_level = LV_LOW;
        spmq_pkg::CLASS_MEDIUM:   req_level = LV_MED;
        spmq_pkg::CLASS_HIGH:     req_level = LV_HIGH;
        default:                  req_level = LV_TOP;
      endcase
    end else begin
      req_level = 11'(level);
    end
    if (req_level > LV_MAX) begin
      push_level = LW'(LV_MAX);
    end else begin
      push_level = LW'(req_level);
    end
  end

  assign accept     = start & ~busy;
  assign lvl_in     = (kind == spmq_pkg::KIND_POP) ? highest_level : push_level;
  assign reject_pop = (kind == spmq_pkg::KIND_POP) &
                      (stop_flag | suspend_flag | ~highest_valid);

  // an empty level reads as head 0, fill 0
  assign eff_head = nonempty[lvl_q] ? ctrl_rd[CTW-1:FW] : '0;
  assign eff_fill = nonempty[lvl_q] ? ctrl_rd[FW-1:0]   : '0;
  assign is_full  = (eff_fill == FW'(QUEUE_DEPTH));
  assign tail_sum = SW'(eff_head) + SW'(eff_fill);
  assign tail_pos = (tail_sum >= SW'(QUEUE_DEPTH)) ? HW'(tail_sum - SW'(QUEUE_DEPTH))
                                                    : HW'(tail_sum);
  assign head_inc = (eff_head == HW'(QUEUE_DEPTH - 1)) ? '0 : eff_head + 1'b1;

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      spmq_pkg::ST_IDLE: begin
        if (accept && !reject_pop) begin
          state_next = spmq_pkg::ST_CTRL;
        end
      end
      spmq_pkg::ST_CTRL: begin
        state_next = (kind_q == spmq_pkg::KIND_POP) ? spmq_pkg::ST_RDATA : spmq_pkg::ST_IDLE;
      end
      spmq_pkg::ST_RDATA: begin
        state_next = (pop_last && lvl_q != '0) ? spmq_pkg::ST_SCAN : spmq_pkg::ST_IDLE;
      end
      spmq_pkg::ST_SCAN: begin
        if (nonempty[scan_idx] || scan_idx == '0) begin
          state_next = spmq_pkg::ST_IDLE;
        end
      end
      default: state_next = spmq_pkg::ST_IDLE;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    busy       = 1'b1;
    ctrl_re    = 1'b0;
    ctrl_we    = 1'b0;
    ctrl_wdata = {eff_head, eff_fill};
    tm_we      = 1'b0;
    tm_re      = 1'b0;
    tm_addr    = AW'(lvl_q) * AW'(QUEUE_DEPTH) + AW'(eff_head);
    case (state)
      spmq_pkg::ST_IDLE: begin
        busy    = 1'b0;
        ctrl_re = accept;
      end
      spmq_pkg::ST_CTRL: begin
        if (kind_q == spmq_pkg::KIND_PUSH) begin
          ctrl_we    = ~is_full;
          ctrl_wdata = {eff_head, eff_fill + 1'b1};
          tm_we      = ~is_full;
          tm_addr    = AW'(lvl_q) * AW'(QUEUE_DEPTH) + AW'(tail_pos);
        end else begin
          ctrl_we    = 1'b1;
          ctrl_wdata = {head_inc, eff_fill - 1'b1};
          tm_re      = 1'b1;
        end
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // ---------------- memories ----------------
  always_ff @(posedge clk) begin
    if (ctrl_we) begin
      ctrl_mem[lvl_q] <= ctrl_wdata;
    end
    if (ctrl_re) begin
      ctrl_rd <= ctrl_mem[lvl_in];
    end
  end

  always_ff @(posedge clk) begin
    if (tm_we) begin
      task_mem[tm_addr] <= handle_q;
    end
    if (tm_re) begin
      tm_rdata <= task_mem[tm_addr];
    end
  end

  // ---------------- control state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= spmq_pkg::ST_IDLE;
      done_q        <= 1'b0;
      nonempty      <= '0;
      count         <= '0;
      highest_valid <= 1'b0;
      highest_level <= '0;
    end else begin
      state  <= state_next;
      done_q <= 1'b0;
      case (state)
        spmq_pkg::ST_IDLE: begin
          if (accept && reject_pop) begin
            done_q <= 1'b1;
          end
        end
        spmq_pkg::ST_CTRL: begin
          if (kind_q == spmq_pkg::KIND_PUSH) begin
            done_q <= 1'b1;
            if (!is_full) begin
              count           <= count + 1'b1;
              nonempty[lvl_q] <= 1'b1;
              if (!highest_valid || lvl_q > highest_level) begin
                highest_valid <= 1'b1;
                highest_level <= lvl_q;
              end
            end
          end else begin
            count <= count - 1'b1;
            if (eff_fill == FW'(1)) begin
              nonempty[lvl_q] <= 1'b0;
            end
          end
        end
        spmq_pkg::ST_RDATA: begin
          if (!pop_last) begin
            done_q <= 1'b1;
          end else if (lvl_q == '0) begin
            done_q        <= 1'b1;
            highest_valid <= 1'b0;
            highest_level <= '0;
          end
        end
        spmq_pkg::ST_SCAN: begin
          if (nonempty[scan_idx]) begin
            done_q        <= 1'b1;
            highest_valid <= 1'b1;
            highest_level <= scan_idx;
          end else if (scan_idx == '0) begin
            done_q        <= 1'b1;
            highest_valid <= 1'b0;
            highest_level <= '0;
          end
        end
        default: begin
          done_q <= 1'b0;
        end
      endcase
    end
  end

  // ---------------- payload ----------------
  always_ff @(posedge clk) begin
    case (state)
      spmq_pkg::ST_IDLE: begin
        if (accept) begin
          kind_q   <= kind;
          handle_q <= task_handle;
          lvl_q    <= lvl_in;
          if (reject_pop) begin
            res_handle <= '0;
            res_level  <= '0;
            if (stop_flag) begin
              res_status <= spmq_pkg::STS_STOPPED;
            end else if (suspend_flag) begin
              res_status <= spmq_pkg::STS_SUSPEND;
            end else begin
              res_status <= spmq_pkg::STS_EMPTY;
            end
          end
        end
      end
      spmq_pkg::ST_CTRL: begin
        res_level  <= lvl_q;
        res_handle <= '0;
        pop_last   <= (eff_fill == FW'(1));
        scan_idx   <= lvl_q - 1'b1;
        if (kind_q == spmq_pkg::KIND_PUSH) begin
          res_status <= is_full ? spmq_pkg::STS_DROPPED : spmq_pkg::STS_PUSHED;
        end else begin
          res_status <= spmq_pkg::STS_POPPED;
        end
      end
      spmq_pkg::ST_RDATA: begin
        res_handle <= tm_rdata;
      end
      spmq_pkg::ST_SCAN: begin
        if (!nonempty[scan_idx] && scan_idx != '0) begin
          scan_idx <= scan_idx - 1'b1;
        end
      end
      default: begin
        res_handle <= res_handle;
      end
    endcase
  end

  assign done        = done_q;
  assign status      = res_status;
  assign out_handle  = 16'(res_handle);
  assign out_level   = 3'(res_level);
  assign total_count = 8'(count);
  assign top_valid   = highest_valid;
  assign top_level   = 3'(highest_level);

  // ---------------- assertions ----------------
  a_top_matches_flags: assert property (@(posedge clk) disable iff (rst)
    (state == spmq_pkg::ST_IDLE) |-> (highest_valid == (nonempty != '0)))
    else $error("top_valid disagrees with non-empty flags");

  a_count_matches_flags: assert property (@(posedge clk) disable iff (rst)
    (state == spmq_pkg::ST_IDLE) |-> ((count == '0) == (nonempty == '0)))
    else $error("task count disagrees with non-empty flags");

  a_top_level_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == spmq_pkg::ST_IDLE && highest_valid) |-> nonempty[highest_level])
    else $error("highest level points at an empty queue");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || done))
    else $error("accepted request neither in flight nor completed");

  a_scan_below: assert property (@(posedge clk) disable iff (rst)
    (state == spmq_pkg::ST_SCAN) |-> (scan_idx < lvl_q))
    else $error("priority scan above the emptied level");

endmodule
